// File: rtl/oate_pkg.sv
package oate_pkg;

	// Request and response beats
	typedef struct packed {
		logic [2:0]         op;
		logic [4:0]         position;
		logic signed [31:0] operand_value;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] found_position;
		logic [4:0] count_now;
	} rsp_t;

	// Request op codes
	localparam logic [2:0] OP_APPEND = 3'd0;
	localparam logic [2:0] OP_INSERT = 3'd1;
	localparam logic [2:0] OP_DELETE = 3'd2;
	localparam logic [2:0] OP_LSRCH  = 3'd3;
	localparam logic [2:0] OP_BSRCH  = 3'd4;

	// Response status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_BAD  = 2'd1;
	localparam logic [1:0] STAT_MISS = 2'd2;

	// Microprogram steps
	typedef enum logic [4:0] {
		U_IDLE, U_FIN, U_BAD, U_MISS, U_OK,
		U_AP0, U_AP1,
		U_IN0, U_IN1, U_IN2, U_IN3,
		U_DL0, U_DL1, U_DL2, U_DL3,
		U_LS0, U_LS1, U_LS2, U_LS3, U_LS4, U_LS5,
		U_BS0, U_BS1, U_BS2, U_BS3
	} step_t;

	// Jump conditions
	typedef enum logic [3:0] {
		CD_ALWAYS, CD_REQ, CD_FULL, CD_INS_BAD, CD_DEL_BAD, CD_IDX_LE_POS,
		CD_IDXP1_GE_CNT, CD_IDX_GE_CNT, CD_EQ, CD_IDX_ONE, CD_LO_GT_HI,
		CD_OUT_FREE
	} cond_t;

	// Memory address sources
	typedef enum logic [2:0] {
		AS_IDX, AS_IDXM1, AS_IDXP1, AS_IDXM2, AS_CNT, AS_POS, AS_MID
	} asel_t;

	typedef enum logic {WD_VAL, WD_RDATA} wsel_t;

	typedef enum logic [2:0] {
		IX_HOLD, IX_ZERO, IX_CNT, IX_POS, IX_INC, IX_DEC, IX_MID
	} idx_op_t;

	typedef enum logic [1:0] {CN_HOLD, CN_INC, CN_DEC} cnt_op_t;
	typedef enum logic [1:0] {LH_HOLD, LH_INIT, LH_STEP} lh_op_t;
	typedef enum logic [1:0] {SO_HOLD, SO_OK, SO_BAD, SO_MISS} st_op_t;
	typedef enum logic [1:0] {FO_HOLD, FO_IDX, FO_IDXM1} fnd_op_t;

	// One control word
	typedef struct packed {
		cond_t   cond;
		step_t   tgt;
		step_t   nxt;
		logic    dispatch;
		asel_t   rsel;
		logic    we;
		asel_t   wsel;
		wsel_t   wdata;
		idx_op_t idx_op;
		cnt_op_t cnt_op;
		lh_op_t  lh_op;
		st_op_t  st_op;
		fnd_op_t fnd_op;
		logic    emit;
	} ctl_t;

	localparam ctl_t CTL_NOP = '{
		cond: CD_ALWAYS, tgt: U_FIN, nxt: U_FIN, dispatch: 1'b0,
		rsel: AS_IDX, we: 1'b0, wsel: AS_IDX, wdata: WD_VAL,
		idx_op: IX_HOLD, cnt_op: CN_HOLD, lh_op: LH_HOLD,
		st_op: SO_HOLD, fnd_op: FO_HOLD, emit: 1'b0
	};

	// Control store: one word per step
	function automatic ctl_t ucode(step_t s);
		ctl_t c;
		c = CTL_NOP;
		unique case (s)
			U_IDLE: begin
				c.cond = CD_REQ; c.tgt = U_IDLE; c.nxt = U_IDLE; c.dispatch = 1'b1;
			end
			U_FIN: begin
				c.cond = CD_OUT_FREE; c.tgt = U_IDLE; c.nxt = U_FIN; c.emit = 1'b1;
			end
			U_BAD:  c.st_op = SO_BAD;
			U_MISS: c.st_op = SO_MISS;
			U_OK:   c.st_op = SO_OK;
			U_AP0: begin
				c.cond = CD_FULL; c.tgt = U_BAD; c.nxt = U_AP1;
			end
			U_AP1: begin
				c.we = 1'b1; c.wsel = AS_CNT; c.wdata = WD_VAL;
				c.cnt_op = CN_INC; c.st_op = SO_OK;
			end
			U_IN0: begin
				c.cond = CD_INS_BAD; c.tgt = U_BAD; c.nxt = U_IN1; c.idx_op = IX_CNT;
			end
			U_IN1: begin
				c.cond = CD_IDX_LE_POS; c.tgt = U_IN3; c.nxt = U_IN2;
				c.rsel = AS_IDXM1; c.idx_op = IX_DEC;
			end
			U_IN2: begin
				c.cond = CD_IDX_LE_POS; c.tgt = U_IN3; c.nxt = U_IN2;
				c.rsel = AS_IDXM1; c.idx_op = IX_DEC;
				c.we = 1'b1; c.wsel = AS_IDXP1; c.wdata = WD_RDATA;
			end
			U_IN3: begin
				c.we = 1'b1; c.wsel = AS_POS; c.wdata = WD_VAL;
				c.cnt_op = CN_INC; c.st_op = SO_OK;
			end
			U_DL0: begin
				c.cond = CD_DEL_BAD; c.tgt = U_BAD; c.nxt = U_DL1; c.idx_op = IX_POS;
			end
			U_DL1: begin
				c.cond = CD_IDXP1_GE_CNT; c.tgt = U_DL3; c.nxt = U_DL2;
				c.rsel = AS_IDXP1; c.idx_op = IX_INC;
			end
			U_DL2: begin
				c.cond = CD_IDXP1_GE_CNT; c.tgt = U_DL3; c.nxt = U_DL2;
				c.rsel = AS_IDXP1; c.idx_op = IX_INC;
				c.we = 1'b1; c.wsel = AS_IDXM1; c.wdata = WD_RDATA;
			end
			U_DL3: begin
				c.cnt_op = CN_DEC; c.st_op = SO_OK;
			end
			U_LS0: begin
				c.tgt = U_LS1; c.idx_op = IX_ZERO;
			end
			U_LS1: begin
				c.cond = CD_IDX_GE_CNT; c.tgt = U_MISS; c.nxt = U_LS2;
				c.rsel = AS_IDX; c.idx_op = IX_INC;
			end
			U_LS2: begin
				c.cond = CD_EQ; c.tgt = U_LS3; c.nxt = U_LS1;
			end
			U_LS3: begin
				c.cond = CD_IDX_ONE; c.tgt = U_OK; c.nxt = U_LS4;
				c.rsel = AS_IDXM2; c.fnd_op = FO_IDXM1;
			end
			U_LS4: begin
				c.tgt = U_LS5; c.we = 1'b1; c.wsel = AS_IDXM1; c.wdata = WD_RDATA;
			end
			U_LS5: begin
				c.we = 1'b1; c.wsel = AS_IDXM2; c.wdata = WD_VAL; c.st_op = SO_OK;
			end
			U_BS0: begin
				c.tgt = U_BS1; c.lh_op = LH_INIT;
			end
			U_BS1: begin
				c.cond = CD_LO_GT_HI; c.tgt = U_MISS; c.nxt = U_BS2;
				c.rsel = AS_MID; c.idx_op = IX_MID;
			end
			U_BS2: begin
				c.cond = CD_EQ; c.tgt = U_BS3; c.nxt = U_BS1; c.lh_op = LH_STEP;
			end
			U_BS3: begin
				c.fnd_op = FO_IDX; c.st_op = SO_OK;
			end
			default: c = CTL_NOP;
		endcase
		return c;
	endfunction

	// Entry step for a request op
	function automatic step_t entry_step(logic [2:0] op);
		step_t s;
		s = U_BAD;
		unique case (op)
			OP_APPEND: s = U_AP0;
			OP_INSERT: s = U_IN0;
			OP_DELETE: s = U_DL0;
			OP_LSRCH:  s = U_LS0;
			OP_BSRCH:  s = U_BS0;
			default:   s = U_BAD;
		endcase
		return s;
	endfunction

endpackage

// File: rtl/ordered_array_table_engine_unit.sv
// Ordered array table engine: a dense array of signed 32-bit words with a
// count of entries in use. Each request beat on req (valid/ready) names one
// op: append, insert at an index, delete at an index, linear search that
// moves a hit one place toward the front, or binary search over a sorted
// array. Each request yields exactly one response beat on rsp carrying a
// status, the index where a key was found and the entry count afterward.
// A microcoded sequencer steps a word store with one write and one
// registered read per cycle. A new request is taken in the idle step,
// the cycle after the previous response is loaded, even while that
// response still waits in the output register; if rsp stalls, the
// sequencer holds at its final step until the slot frees.
// Reset empties the table (count zero); the store itself is not cleared,
// since only entries below the count are ever used.
module ordered_array_table_engine_unit #(
	parameter int CAPACITY = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  oate_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output oate_pkg::rsp_t  rsp
);
	import oate_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int XW = (CW > 5) ? CW : 5;

	logic [31:0]         store_q [CAPACITY];
	logic [31:0]         rd_data_q;
	step_t               step_q, step_d;
	ctl_t                ctl;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       found_q;
	logic signed [CW:0]  lo_q, hi_q;
	logic [4:0]          pos_q;
	logic [31:0]         val_q;
	logic [1:0]          status_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic                accept, out_free, taken, emit;
	logic [XW-1:0]       idx_x, cnt_x, pos_x;
	logic signed [CW+1:0] lh_sum;
	logic [CW-1:0]       mid;
	logic [CW-1:0]       raddr_w, waddr_w;
	logic [31:0]         wdata_w;
	logic                key_eq, key_less;

	// Decode the current step
	always_comb begin
		ctl = ucode(step_q);
	end

	assign req_ready = (step_q == U_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign emit      = ctl.emit && out_free;

	// Compare helpers
	assign idx_x    = XW'(idx_q);
	assign cnt_x    = XW'(cnt_q);
	assign pos_x    = XW'(pos_q);
	assign lh_sum   = (CW+2)'(lo_q) + (CW+2)'(hi_q);
	assign mid      = lh_sum[CW:1];
	assign key_eq   = (rd_data_q == val_q);
	assign key_less = ($signed(rd_data_q) < $signed(val_q));

	// Evaluate jump condition
	always_comb begin
		unique case (ctl.cond)
			CD_ALWAYS:       taken = 1'b1;
			CD_REQ:          taken = req_valid;
			CD_FULL:         taken = (cnt_q == CW'(CAPACITY));
			CD_INS_BAD:      taken = (cnt_q == CW'(CAPACITY)) || (pos_x > cnt_x);
			CD_DEL_BAD:      taken = (pos_x >= cnt_x);
			CD_IDX_LE_POS:   taken = (idx_x <= pos_x);
			CD_IDXP1_GE_CNT: taken = ((idx_q + CW'(1)) >= cnt_q);
			CD_IDX_GE_CNT:   taken = (idx_q >= cnt_q);
			CD_EQ:           taken = key_eq;
			CD_IDX_ONE:      taken = (idx_q == CW'(1));
			CD_LO_GT_HI:     taken = (lo_q > hi_q);
			CD_OUT_FREE:     taken = out_free;
			default:         taken = 1'b1;
		endcase
	end

	// Next step
	always_comb begin
		if (ctl.dispatch && taken) begin
			step_d = entry_step(req.op);
		end else if (taken) begin
			step_d = ctl.tgt;
		end else begin
			step_d = ctl.nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= U_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// Address and write data selection
	function automatic logic [CW-1:0] pick_addr(asel_t s, logic [CW-1:0] idx,
			logic [CW-1:0] cnt, logic [4:0] pos, logic [CW-1:0] md);
		logic [CW-1:0] a;
		a = idx;
		case (s)
			AS_IDX:   a = idx;
			AS_IDXM1: a = idx - CW'(1);
			AS_IDXP1: a = idx + CW'(1);
			AS_IDXM2: a = idx - CW'(2);
			AS_CNT:   a = cnt;
			AS_POS:   a = CW'(pos);
			AS_MID:   a = md;
			default:  a = idx;
		endcase
		return a;
	endfunction

	assign raddr_w = pick_addr(ctl.rsel, idx_q, cnt_q, pos_q, mid);
	assign waddr_w = pick_addr(ctl.wsel, idx_q, cnt_q, pos_q, mid);
	assign wdata_w = (ctl.wdata == WD_RDATA) ? rd_data_q : val_q;

	// Word store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			store_q[waddr_w[AW-1:0]] <= wdata_w;
		end
		rd_data_q <= store_q[raddr_w[AW-1:0]];
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (ctl.cnt_op)
				CN_INC:  cnt_q <= cnt_q + CW'(1);
				CN_DEC:  cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Datapath registers: latch request, walk index, search bounds, result
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q <= req.position;
			val_q <= req.operand_value;
		end

		case (ctl.idx_op)
			IX_ZERO: idx_q <= '0;
			IX_CNT:  idx_q <= cnt_q;
			IX_POS:  idx_q <= CW'(pos_q);
			IX_INC:  idx_q <= idx_q + CW'(1);
			IX_DEC:  idx_q <= idx_q - CW'(1);
			IX_MID:  idx_q <= mid;
			default: idx_q <= idx_q;
		endcase

		case (ctl.lh_op)
			LH_INIT: begin
				lo_q <= '0;
				hi_q <= $signed({1'b0, cnt_q}) - (CW+1)'(1);
			end
			LH_STEP: begin
				if (key_less) begin
					lo_q <= $signed({1'b0, idx_q}) + (CW+1)'(1);
				end else begin
					hi_q <= $signed({1'b0, idx_q}) - (CW+1)'(1);
				end
			end
			default: begin
				lo_q <= lo_q;
				hi_q <= hi_q;
			end
		endcase

		if (accept) begin
			found_q <= '0;
		end else begin
			case (ctl.fnd_op)
				FO_IDX:   found_q <= idx_q;
				FO_IDXM1: found_q <= idx_q - CW'(1);
				default:  found_q <= found_q;
			endcase
		end

		case (ctl.st_op)
			SO_OK:   status_q <= STAT_OK;
			SO_BAD:  status_q <= STAT_BAD;
			SO_MISS: status_q <= STAT_MISS;
			default: status_q <= status_q;
		endcase

		if (emit) begin
			rsp_q.status         <= status_q;
			rsp_q.found_position <= 4'(found_q);
			rsp_q.count_now      <= 5'(cnt_q);
		end
	end

	// Output register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: tb/tb_ordered_array_table_engine_unit.sv
`timescale 1ns / 100ps

module tb_ordered_array_table_engine_unit;
	import oate_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD = 400;
	localparam int DRAIN_CYCLES = 60;

	// Op codes the block answers with a bad status
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	// Contents of the table as seen from outside
	typedef struct packed {
		logic [TABLE_DEPTH-1:0][31:0] word;
		logic [4:0]                   cnt;
	} table_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	req_t request_q[$];
	rsp_t answer_q[$];
	table_t gen_table = '0;
	table_t live_table = '0;
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	logic long_hold_arm = 1'b0;
	logic long_hold_taken;
	int hold_left;
	int mismatches = 0;
	int quiet_cycles = 0;

	ordered_array_table_engine_unit #(
		.CAPACITY(TABLE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Apply one request to a table and return the answer it produces
	function automatic rsp_t table_apply(inout table_t t, input req_t r);
		rsp_t o;
		int k;
		int lo;
		int hi;
		int mid;
		logic [31:0] held;
		o.status = STAT_OK;
		o.found_position = '0;
		case (r.op)
			OP_APPEND: begin
				if (t.cnt >= TABLE_DEPTH) begin
					o.status = STAT_BAD;
				end else begin
					t.word[t.cnt[3:0]] = r.operand_value;
					t.cnt = t.cnt + 5'd1;
				end
			end
			OP_INSERT: begin
				if (t.cnt >= TABLE_DEPTH || r.position > t.cnt) begin
					o.status = STAT_BAD;
				end else begin
					for (k = int'(t.cnt); k > int'(r.position); k--)
						t.word[k] = t.word[k-1];
					t.word[r.position[3:0]] = r.operand_value;
					t.cnt = t.cnt + 5'd1;
				end
			end
			OP_DELETE: begin
				if (r.position >= t.cnt) begin
					o.status = STAT_BAD;
				end else begin
					for (k = int'(r.position); k + 1 < int'(t.cnt); k++)
						t.word[k] = t.word[k+1];
					t.cnt = t.cnt - 5'd1;
				end
			end
			OP_LSRCH: begin
				o.status = STAT_MISS;
				for (k = 0; k < int'(t.cnt); k++) begin
					if (t.word[k] == r.operand_value) begin
						// move the hit one place toward the front
						if (k > 0) begin
							held = t.word[k];
							t.word[k] = t.word[k-1];
							t.word[k-1] = held;
						end
						o.status = STAT_OK;
						o.found_position = 4'(k);
						break;
					end
				end
			end
			OP_BSRCH: begin
				o.status = STAT_MISS;
				lo = 0;
				hi = int'(t.cnt) - 1;
				while (lo <= hi) begin
					mid = (lo + hi) / 2;
					if (t.word[mid] == r.operand_value) begin
						o.status = STAT_OK;
						o.found_position = 4'(mid);
						break;
					end else if ($signed(t.word[mid]) < r.operand_value) begin
						lo = mid + 1;
					end else begin
						hi = mid - 1;
					end
				end
			end
			default: o.status = STAT_BAD;
		endcase
		o.count_now = t.cnt;
		return o;
	endfunction

	// Mix of full-range, small, and extreme words
	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6:    return 32'($urandom_range(0, 16)) - 32'd8;
			7:          return 32'h8000_0000;
			8:          return 32'h7fff_ffff;
			default:    return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
		endcase
	endfunction

	// Mostly a key that is present in the table
	function automatic logic [31:0] pick_key();
		if (gen_table.cnt != 0 && $urandom_range(0, 9) < 7)
			return gen_table.word[$urandom_range(0, int'(gen_table.cnt) - 1)];
		return rand_value();
	endfunction

	// Index that keeps the table in ascending signed order
	function automatic logic [4:0] sorted_slot(logic [31:0] v);
		int k;
		k = 0;
		while (k < int'(gen_table.cnt) && $signed(gen_table.word[k]) <= $signed(v))
			k++;
		return 5'(k);
	endfunction

	task automatic queue_req(input logic [2:0] op, input logic [4:0] pos,
		input logic [31:0] v);
		req_t r;
		r.op = op;
		r.position = pos;
		r.operand_value = v;
		void'(table_apply(gen_table, r));
		request_q.push_back(r);
	endtask

	task automatic add_random_item(input bit sorted, input int idx);
		int r;
		int cnt;
		int grow;
		int shrink;
		logic [2:0] op;
		logic [4:0] pos;
		logic [31:0] v;
		cnt = int'(gen_table.cnt);
		r = $urandom_range(0, 99);
		v = rand_value();
		pos = 5'($urandom_range(0, TABLE_DEPTH));
		// alternate filling and draining stretches so the count wanders
		grow = ((idx / 40) % 2 == 1) ? 8 : 22;
		shrink = ((idx / 40) % 2 == 1) ? 40 : 14;
		if (r < 4) begin
			op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		end else if (sorted) begin
			if (r < 40) begin
				op = OP_INSERT;
				if (r >= 8)
					pos = sorted_slot(v);
			end else if (r < 40 + shrink / 2) begin
				op = OP_DELETE;
				if (cnt > 0 && r >= 43)
					pos = 5'($urandom_range(0, cnt - 1));
			end else begin
				op = OP_BSRCH;
				v = pick_key();
			end
		end else if (r < 4 + grow) begin
			op = OP_APPEND;
		end else if (r < 4 + 2 * grow) begin
			op = OP_INSERT;
			if ($urandom_range(0, 99) < 88)
				pos = 5'($urandom_range(0, cnt));
		end else if (r < 4 + 2 * grow + shrink) begin
			op = OP_DELETE;
			if (cnt > 0 && $urandom_range(0, 99) < 88)
				pos = 5'($urandom_range(0, cnt - 1));
		end else begin
			op = r[0] ? OP_LSRCH : OP_BSRCH;
			v = pick_key();
		end
		queue_req(op, pos, v);
	endtask

	// Wait until every request is sent and every answer is back; sample
	// between edges so the driver and monitor updates have settled
	task automatic wait_drained();
		while (request_q.size() != 0 || req_valid || answer_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(input int src_pct, input int snk_pct, input bit sorted,
		input int n_items);
		int i;
		src_idle_pct = src_pct;
		snk_stall_pct = snk_pct;
		// empty the table first so sorted inserts build an ordered table
		if (sorted) begin
			while (gen_table.cnt != 0)
				queue_req(OP_DELETE, 5'd0, rand_value());
		end
		for (i = 0; i < n_items; i++)
			add_random_item(sorted, i);
		wait_drained();
	endtask

	// Send requests; hold the beat until it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			live_table <= '0;
		end else begin
			if (req_valid && req_ready)
				answer_q.push_back(table_apply(live_table, req));
			if (!req_valid || req_ready) begin
				if (request_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					req_valid <= 1'b1;
					req <= request_q.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Check each response beat against the oldest answer; drive rsp_ready
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			hold_left <= 0;
			long_hold_taken <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (answer_q.size() == 0) begin
					$error("response with no request outstanding: status %0d index %0d count %0d",
						rsp.status, rsp.found_position, rsp.count_now);
					mismatches++;
				end else begin
					want = answer_q.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						mismatches++;
					end
					if (rsp.found_position !== want.found_position) begin
						$error("found_position: expected %0d, got %0d",
							want.found_position, rsp.found_position);
						mismatches++;
					end
					if (rsp.count_now !== want.count_now) begin
						$error("count_now: expected %0d, got %0d", want.count_now, rsp.count_now);
						mismatches++;
					end
				end
			end
			// hold off for a long stretch once, when armed
			if (long_hold_arm && !long_hold_taken) begin
				long_hold_taken <= 1'b1;
				hold_left <= LONG_HOLD;
				rsp_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
			end
		end
	end

	// End the run when no beat moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: searches miss, bad delete and insert index
		queue_req(OP_BSRCH, 5'd0, 32'h0);
		queue_req(OP_LSRCH, 5'd3, 32'h0);
		queue_req(OP_DELETE, 5'd0, 32'd5);
		queue_req(OP_INSERT, 5'd1, 32'd5);
		// Build an ordered table of the extremes
		queue_req(OP_INSERT, 5'd0, 32'h7fff_ffff);
		queue_req(OP_INSERT, 5'd0, 32'h8000_0000);
		queue_req(OP_INSERT, 5'd1, 32'hffff_ffff);
		queue_req(OP_INSERT, 5'd2, 32'h0);
		queue_req(OP_BSRCH, 5'd16, 32'h7fff_ffff);
		queue_req(OP_BSRCH, 5'd0, 32'h8000_0000);
		queue_req(OP_BSRCH, 5'd0, 32'd5);
		// Hit at the front does no swap; a later hit swaps
		queue_req(OP_LSRCH, 5'd0, 32'h8000_0000);
		queue_req(OP_LSRCH, 5'd0, 32'h0);
		// Table is now out of order
		queue_req(OP_BSRCH, 5'd0, 32'hffff_ffff);
		queue_req(OP_DELETE, 5'd4, 32'h0);
		queue_req(OP_DELETE, 5'd3, 32'h0);
		queue_req(OP_DELETE, 5'd0, 32'h0);
		queue_req(OP_UNUSED_LO, 5'd0, 32'h0);
		queue_req(OP_UNUSED_HI, 5'd31, 32'hffff_ffff);
		// Fill up, then append and insert on a full table
		while (gen_table.cnt < TABLE_DEPTH - 1)
			queue_req(OP_APPEND, 5'd16, rand_value());
		queue_req(OP_APPEND, 5'd0, 32'h1357_9bdf);
		queue_req(OP_APPEND, 5'd0, 32'd1);
		queue_req(OP_INSERT, 5'd16, 32'd1);
		queue_req(OP_INSERT, 5'd0, 32'd1);
		queue_req(OP_LSRCH, 5'd0, 32'h1357_9bdf);
		queue_req(OP_DELETE, 5'd15, 32'h0);
		wait_drained();

		run_phase(0, 0, 1'b0, 200);
		run_phase(85, 0, 1'b1, 150);
		run_phase(0, 85, 1'b0, 150);
		run_phase(14, 14, 1'b1, 150);
		run_phase(14, 14, 1'b0, 150);
		// Receiver holds off while the sender keeps offering beats
		long_hold_arm <= 1'b1;
		run_phase(0, 0, 1'b0, 100);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (answer_q.size() != 0)
			$error("%0d responses never arrived", answer_q.size());
		if (mismatches == 0 && answer_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/oate_pkg.sv
rtl/ordered_array_table_engine_unit.sv
tb/tb_ordered_array_table_engine_unit.sv
